// ===== rtl/core/utrt_pkg.sv =====
// shared types, widths and the digit-to-ascii map for the radix text converter
// no dependencies
package utrt_pkg;

    localparam int VALUE_PORT_W = 64;
    localparam int RADIX_W      = 6;
    localparam int MAXD_W       = 7;
    localparam int DIGIT_W      = 6;
    localparam int CHAR_W       = 7;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 7;

    localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIGITS = 1'b1;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [MAXD_W-1:0]  MAXD_RESET  = 7'd64;

    localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0]  CHAR_A     = 7'h61;

    // divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } utrt_div_stat_t;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_DIGITS) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_A + CHAR_W'(d - DEC_DIGITS);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/utrt_div.sv =====
// one restoring division step: shift a dividend bit into the partial remainder,
// compare with the radix and subtract when it fits; depends on utrt_pkg
module utrt_div (
    input  logic [utrt_pkg::RADIX_W-1:0] rem_in,
    input  logic                         bit_in,
    input  logic [utrt_pkg::RADIX_W-1:0] divisor,
    output logic [utrt_pkg::RADIX_W-1:0] rem_out,
    output logic                         q_bit
);

    logic [utrt_pkg::RADIX_W:0] trial;
    logic [utrt_pkg::RADIX_W:0] diff;
    logic                       ge;

    assign trial   = {rem_in, bit_in};
    assign ge      = (trial >= {1'b0, divisor});
    assign diff    = trial - {1'b0, divisor};
    assign rem_out = ge ? diff[utrt_pkg::RADIX_W-1:0] : trial[utrt_pkg::RADIX_W-1:0];
    assign q_bit   = ge;

endmodule

// ===== rtl/core/utrt_divider.sv =====
// bit-serial restoring divider of a wide value by a small radix, one bit per cycle
// depends on utrt_pkg and utrt_div
module utrt_divider #(
    parameter int W = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [W-1:0]                 dividend,
    input  logic [utrt_pkg::RADIX_W-1:0] divisor,
    output utrt_pkg::utrt_div_stat_t     stat,
    output logic [W-1:0]                 quotient,
    output logic [utrt_pkg::RADIX_W-1:0] remainder
);

    localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [W-1:0]                 q_reg, q_next;
    logic [utrt_pkg::RADIX_W-1:0] r_reg, r_next;
    logic [utrt_pkg::RADIX_W-1:0] step_rem;
    logic                         step_bit;

    // shift the next dividend bit into the partial remainder
    utrt_div u_step (
        .rem_in  (r_reg),
        .bit_in  (q_reg[W-1]),
        .divisor (divisor),
        .rem_out (step_rem),
        .q_bit   (step_bit)
    );

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(W - 1);
            q_next    = dividend;
            r_next    = '0;
        end else if (busy_reg) begin
            // quotient bits fill in from the bottom as dividend bits leave the top
            q_next = {q_reg[W-2:0], step_bit};
            r_next = step_rem;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

// ===== rtl/core/utrt_store.sv =====
// digit store: one write port, one registered read port
// depends on utrt_pkg
module utrt_store #(
    parameter int DEPTH = 64
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic [utrt_pkg::DIGIT_W-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic [utrt_pkg::DIGIT_W-1:0] rd_data
);

    logic [utrt_pkg::DIGIT_W-1:0] mem [DEPTH];
    logic [utrt_pkg::DIGIT_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/unsigned_to_radix_text.sv =====
// top level: unsigned value to lower-case radix text, one digit word per result
// depends on utrt_pkg, utrt_divider, utrt_store
//
//  channel   ports                                     direction
//  s_        s_valid s_ready s_value[63:0]             value in
//  m_        m_valid m_ready m_digit_char m_last_digit digit out
//  cfg_      cfg_wr_en cfg_index cfg_wdata             register write
//
// each digit takes a full pass over the value on the shared bit-serial divider; once all
// digits are converted, each leaves the digit store through a read state and then a
// present state (read, then present); s_ready is high only when idle
// synchronous active-low reset sets radix 10 and a 64-digit limit; no clearing pass
// a stall on m_ready holds the current digit word and freezes the sequencer
module unsigned_to_radix_text #(
    parameter int VALUE_WIDTH = 64,
    parameter int DIGIT_DEPTH = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [utrt_pkg::VALUE_PORT_W-1:0] s_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [utrt_pkg::CHAR_W-1:0]     m_digit_char,
    output logic                            m_last_digit,
    input  logic                            cfg_wr_en,
    input  logic [utrt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [utrt_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int IDX_W = $clog2(DIGIT_DEPTH);
    localparam int CNT_W = $clog2(DIGIT_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_READ = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t                       state_reg, state_next;
    logic [utrt_pkg::RADIX_W-1:0] radix_reg, radix_next;
    logic [utrt_pkg::MAXD_W-1:0]  maxd_reg, maxd_next;
    logic [utrt_pkg::RADIX_W-1:0] rad_eff_reg, rad_eff_next;
    logic [CNT_W-1:0]             limit_reg, limit_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [IDX_W-1:0]             idx_reg, idx_next;

    logic [utrt_pkg::RADIX_W-1:0] rad_eff;
    logic [CNT_W-1:0]             limit_eff;
    logic [CNT_W-1:0]             count_inc;

    logic                         div_start;
    logic [VALUE_WIDTH-1:0]       div_dividend;
    utrt_pkg::utrt_div_stat_t     div_stat;
    logic [VALUE_WIDTH-1:0]       div_quot;
    logic [utrt_pkg::RADIX_W-1:0] div_rem;

    logic                         wr_en;
    logic                         rd_en;
    logic [utrt_pkg::DIGIT_W-1:0] rd_data;

    // clamp the configured radix and digit limit
    always_comb begin
        if (radix_reg < utrt_pkg::RADIX_MIN) begin
            rad_eff = utrt_pkg::RADIX_MIN;
        end else if (radix_reg > utrt_pkg::RADIX_MAX) begin
            rad_eff = utrt_pkg::RADIX_MAX;
        end else begin
            rad_eff = radix_reg;
        end
        if (maxd_reg == '0) begin
            limit_eff = CNT_W'(1);
        end else if (maxd_reg > utrt_pkg::MAXD_W'(DIGIT_DEPTH)) begin
            limit_eff = CNT_W'(DIGIT_DEPTH);
        end else begin
            limit_eff = CNT_W'(maxd_reg);
        end
    end

    assign count_inc = count_reg + 1'b1;

    always_comb begin
        radix_next   = radix_reg;
        maxd_next    = maxd_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                utrt_pkg::REG_RADIX:      radix_next = cfg_wdata[utrt_pkg::RADIX_W-1:0];
                utrt_pkg::REG_MAX_DIGITS: maxd_next  = cfg_wdata[utrt_pkg::MAXD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next   = state_reg;
        rad_eff_next = rad_eff_reg;
        limit_next   = limit_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        div_start    = 1'b0;
        div_dividend = s_value[VALUE_WIDTH-1:0];
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    rad_eff_next = rad_eff;
                    limit_next   = limit_eff;
                    count_next   = '0;
                    div_start    = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    wr_en      = 1'b1;
                    count_next = count_inc;
                    // keep dividing while digits remain and the limit allows
                    if ((div_quot != '0) && (count_inc < limit_reg)) begin
                        div_dividend = div_quot;
                        div_start    = 1'b1;
                    end else begin
                        idx_next   = count_reg[IDX_W-1:0];
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                rd_en      = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (idx_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            radix_reg <= utrt_pkg::RADIX_RESET;
            maxd_reg  <= utrt_pkg::MAXD_RESET;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            radix_reg <= radix_next;
            maxd_reg  <= maxd_next;
            count_reg <= count_next;
        end
        rad_eff_reg <= rad_eff_next;
        limit_reg   <= limit_next;
        idx_reg     <= idx_next;
    end

    utrt_divider #(
        .W (VALUE_WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   ((state_reg == ST_IDLE) ? rad_eff : rad_eff_reg),
        .stat      (div_stat),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    utrt_store #(
        .DEPTH (DIGIT_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (div_rem),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = (state_reg == ST_OUT);
    assign m_digit_char = utrt_pkg::digit_to_ascii(rd_data);
    assign m_last_digit = (idx_reg == '0);

endmodule
